// File: rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_cell and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

  localparam int SIZE_W   = 12;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL    = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_FREE,
    CMD_MERGE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t op;
    logic      sel_here;
    logic      sel_left;
    logic      beyond;
  } cell_ctl_t;

endpackage

// File: rtl/ffha_cell.sv
// One table entry of the allocator: header offset, data length, free and valid marks.
// Depends on ffha_pkg; neighbors are wired in first_fit_heap_allocator.
module ffha_cell
  import ffha_pkg::*;
#(
  parameter int SW           = 12,
  parameter int HEADER_BYTES = 16,
  parameter int RESET_LEN    = 4080,
  parameter bit FIRST        = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SIZE_W-1:0] size,
  input  logic [SIZE_W-1:0] roff,
  input  logic [SW-1:0]     left_start,
  input  logic [SW-1:0]     left_len,
  input  logic              left_free,
  input  logic              left_valid,
  input  logic [SW-1:0]     right_start,
  input  logic [SW-1:0]     right_len,
  input  logic              right_free,
  input  logic              right_valid,
  output logic [SW-1:0]     start_q,
  output logic [SW-1:0]     len_q,
  output logic              free_q,
  output logic              valid_q,
  output logic              fit,
  output logic              can_split,
  output logic              match,
  output logic [SW:0]       data_pos
);

  localparam int CW = ((SW > SIZE_W) ? SW : SIZE_W) + 2;
  localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);

  logic [SW-1:0] start_r, len_r;
  logic          free_r, valid_r;
  logic [CW-1:0] len_x, size_x, start_x;

  assign len_x    = CW'(len_r);
  assign size_x   = CW'(size);
  assign start_x  = CW'(start_r);
  assign fit       = valid_r & free_r & (len_x >= size_x);
  assign can_split = len_x >= size_x + HDR;
  assign match     = valid_r & ((start_x + HDR) == CW'(roff));
  assign data_pos  = (SW+1)'(start_x + HDR);

  assign start_q = start_r;
  assign len_q   = len_r;
  assign free_q  = free_r;
  assign valid_q = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= FIRST ? SW'(RESET_LEN) : '0;
      free_r  <= FIRST;
      valid_r <= FIRST;
    end else begin
      case (ctl.op)
        CMD_SPLIT: begin
          if (ctl.sel_here) begin
            len_r  <= SW'(size_x);
            free_r <= 1'b0;
          end else if (ctl.sel_left) begin
            start_r <= SW'(CW'(left_start) + HDR + size_x);
            len_r   <= SW'(CW'(left_len) - size_x - HDR);
            free_r  <= 1'b1;
            valid_r <= 1'b1;
          end else if (ctl.beyond) begin
            start_r <= left_start;
            len_r   <= left_len;
            free_r  <= left_free;
            valid_r <= left_valid;
          end
        end
        CMD_TAKE: begin
          if (ctl.sel_here) free_r <= 1'b0;
        end
        CMD_FREE: begin
          if (ctl.sel_here) free_r <= 1'b1;
        end
        CMD_MERGE: begin
          if (ctl.sel_here) begin
            len_r <= SW'(len_x + CW'(right_len) + HDR);
          end else if (ctl.beyond) begin
            start_r <= right_start;
            len_r   <= right_len;
            free_r  <= right_free;
            valid_r <= right_valid;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: a row of table cells plus the request sequencer.
// Depends on ffha_pkg and ffha_cell.
//
// Usage: one input beat per request on in_* (valid/ready). in_kind 0 asks for
// in_request_size bytes; in_kind 1 releases the block whose data starts at
// in_release_offset, or is ignored when in_release_null is set. Every request
// gives exactly one out_* beat carrying out_data_offset and out_status.
// An allocate or an unknown release passes through the evaluate, pick, apply and
// done states; a null release goes from evaluate straight to done. A release
// that frees a block then repeats pair detection followed by a shift-left of the
// cell row once per merge of neighboring free blocks (at most two merges in
// normal operation).
// One request is in flight at a time; the next is accepted once the result has
// been handed to the output register, even if the receiver is stalling it.
// A stalled output holds its beat; the sequencer waits for the output register
// before finishing the next request.
// Reset (synchronous, rst_n low) leaves one free block covering the whole heap.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [SIZE_W-1:0]   in_request_size,
  input  logic [SIZE_W-1:0]   in_release_offset,
  input  logic                in_release_null,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OFFSET_W-1:0] out_data_offset,
  output logic [STATUS_W-1:0] out_status
);

  localparam int SW    = $clog2(HEAP_BYTES);
  localparam int N     = MAX_BLOCKS;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_PICK, S_APPLY, S_MPAIR, S_MERGE, S_DONE} state_t;

  state_t              state_r;
  logic                kind_r, null_r;
  logic [SIZE_W-1:0]   size_r, roff_r;
  logic [N-1:0]        flags_r, split_r, sel_r;
  logic [CNT_W-1:0]    count_r;
  logic [OFFSET_W-1:0] res_off_r, out_off_r;
  logic [STATUS_W-1:0] res_st_r, out_st_r;
  logic                out_valid_r;

  logic [SW-1:0] start_v [N];
  logic [SW-1:0] len_v   [N];
  logic [N-1:0]  free_v, valid_v, fit_v, split_v, match_v, beyond_v, pair_v;
  logic [SW:0]   pos_v   [N];
  logic [SW:0]   pos_or;
  cell_cmd_t     op;

  assign beyond_v = ~(sel_r | (sel_r - N'(1)));

  for (genvar j = 0; j < N; j++) begin : g_cell
    cell_ctl_t ctl;
    logic [SW-1:0] ls, ll, rs, rl;
    logic          lf, lv, rf, rv;
    assign ctl.op       = op;
    assign ctl.sel_here = sel_r[j];
    assign ctl.beyond   = beyond_v[j];
    if (j == 0) begin : g_l0
      assign ctl.sel_left = 1'b0;
      assign ls = '0; assign ll = '0; assign lf = 1'b0; assign lv = 1'b0;
    end else begin : g_ln
      assign ctl.sel_left = sel_r[j-1];
      assign ls = start_v[j-1]; assign ll = len_v[j-1];
      assign lf = free_v[j-1];  assign lv = valid_v[j-1];
    end
    if (j == N-1) begin : g_rl
      assign rs = '0; assign rl = '0; assign rf = 1'b0; assign rv = 1'b0;
      assign pair_v[j] = 1'b0;
    end else begin : g_rn
      assign rs = start_v[j+1]; assign rl = len_v[j+1];
      assign rf = free_v[j+1];  assign rv = valid_v[j+1];
      assign pair_v[j] = valid_v[j] & free_v[j] & valid_v[j+1] & free_v[j+1];
    end

    ffha_cell #(
      .SW(SW), .HEADER_BYTES(HEADER_BYTES),
      .RESET_LEN(HEAP_BYTES - HEADER_BYTES), .FIRST(j == 0)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .size(size_r), .roff(roff_r),
      .left_start(ls), .left_len(ll), .left_free(lf), .left_valid(lv),
      .right_start(rs), .right_len(rl), .right_free(rf), .right_valid(rv),
      .start_q(start_v[j]), .len_q(len_v[j]), .free_q(free_v[j]), .valid_q(valid_v[j]),
      .fit(fit_v[j]), .can_split(split_v[j]), .match(match_v[j]), .data_pos(pos_v[j])
    );
  end

  // The selected cell is one-hot, so an OR over masked positions is a mux.
  always_comb begin
    pos_or = '0;
    for (int j = 0; j < N; j++) begin
      pos_or = pos_or | (pos_v[j] & {(SW+1){sel_r[j]}});
    end
  end

  logic do_split;
  assign do_split = (|(sel_r & split_r)) && (count_r < CNT_W'(MAX_BLOCKS));

  always_comb begin
    op = CMD_NONE;
    unique case (state_r)
      S_APPLY: begin
        if (|sel_r) begin
          if (kind_r == KIND_RELEASE) op = CMD_FREE;
          else op = do_split ? CMD_SPLIT : CMD_TAKE;
        end
      end
      S_MERGE: op = CMD_MERGE;
      default: op = CMD_NONE;
    endcase
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_data_offset = out_off_r;
  assign out_status      = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is handled by the state arm below.
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            size_r  <= in_request_size;
            roff_r  <= in_release_offset;
            null_r  <= in_release_null;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          flags_r   <= (kind_r == KIND_RELEASE) ? match_v : fit_v;
          split_r   <= split_v;
          res_off_r <= '0;
          if (kind_r == KIND_RELEASE && null_r) begin
            res_st_r <= ST_NULL;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          sel_r   <= flags_r & (~flags_r + N'(1));
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (!(|sel_r)) begin
            res_st_r <= (kind_r == KIND_RELEASE) ? ST_UNKNOWN : ST_NO_FIT;
            state_r  <= S_DONE;
          end else if (kind_r == KIND_RELEASE) begin
            res_st_r <= ST_DONE;
            state_r  <= S_MPAIR;
          end else begin
            res_st_r  <= ST_DONE;
            res_off_r <= OFFSET_W'(pos_or);
            if (do_split) count_r <= count_r + CNT_W'(1);
            state_r <= S_DONE;
          end
          sel_r <= '0;
        end
        S_MPAIR: begin
          sel_r   <= pair_v & (~pair_v + N'(1));
          state_r <= (|pair_v) ? S_MERGE : S_DONE;
        end
        S_MERGE: begin
          count_r <= count_r - CNT_W'(1);
          sel_r   <= '0;
          state_r <= S_MPAIR;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_off_r   <= res_off_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sel_r))
    else $error("more than one cell selected");
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == 32'(count_r))
    else $error("block count disagrees with valid cells");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(1) && count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");
  a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("merge did not remove a block");
`endif

endmodule

// File: tb/sv/first_fit_heap_allocator_test.sv
// Self-checking testbench for first_fit_heap_allocator: directed and random allocate and
// release requests are checked against an in-bench model of the block table.
// Depends on ffha_pkg and the allocator RTL.
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int HEAP   = 4096;
  localparam int HDR    = 16;
  localparam int NBLK   = 64;
  localparam int WDOG   = 20000;

  typedef struct {
    logic                kind;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   roff;
    logic                rnull;
  } request_t;

  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [SIZE_W-1:0] in_release_offset = '0;
  logic in_release_null = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OFFSET_W-1:0] out_data_offset;
  logic [STATUS_W-1:0] out_status;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       hold_sender = 1'b0;
  int       hold_receiver = 0;
  int       in_beats = 0;
  int       offered = 0;

  // Shadow of the block table.
  int  tbl_start[NBLK];
  int  tbl_len[NBLK];
  bit  tbl_free[NBLK];
  int  tbl_count;
  int  live_offsets[$];

  first_fit_heap_allocator u_top (.*);

  always #5 clk = ~clk;

  function automatic void table_reset();
    tbl_start[0] = 0;
    tbl_len[0] = HEAP - HDR;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k] = tbl_len[k+1];
      tbl_free[k] = tbl_free[k+1];
    end
    tbl_count--;
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    int i;
    g.offset = '0;
    if (r.kind == KIND_ALLOC) begin
      g.status = ST_NO_FIT;
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_free[i] && tbl_len[i] >= int'(r.size)) begin
          if (tbl_len[i] >= int'(r.size) + HDR && tbl_count < NBLK) begin
            for (int k = tbl_count; k > i + 1; k--) begin
              tbl_start[k] = tbl_start[k-1];
              tbl_len[k] = tbl_len[k-1];
              tbl_free[k] = tbl_free[k-1];
            end
            tbl_start[i+1] = tbl_start[i] + HDR + int'(r.size);
            tbl_len[i+1] = tbl_len[i] - int'(r.size) - HDR;
            tbl_free[i+1] = 1'b1;
            tbl_count++;
            tbl_len[i] = int'(r.size);
          end
          tbl_free[i] = 1'b0;
          g.offset = OFFSET_W'(tbl_start[i] + HDR);
          g.status = ST_DONE;
          break;
        end
      end
    end else if (r.rnull) begin
      g.status = ST_NULL;
    end else begin
      g.status = ST_UNKNOWN;
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_start[i] + HDR == int'(r.roff)) begin
          tbl_free[i] = 1'b1;
          i = 0;
          while (i + 1 < tbl_count) begin
            if (tbl_free[i] && tbl_free[i+1]) begin
              tbl_len[i] += tbl_len[i+1] + HDR;
              drop_entry(i + 1);
            end else begin
              i++;
            end
          end
          g.status = ST_DONE;
          break;
        end
      end
    end
    return g;
  endfunction

  function automatic request_t make_alloc(int sz);
    request_t r;
    r.kind = KIND_ALLOC;
    r.size = SIZE_W'(sz);
    r.roff = SIZE_W'($urandom);
    r.rnull = 1'($urandom);
    return r;
  endfunction

  function automatic request_t make_release(int off, bit nul);
    request_t r;
    r.kind = KIND_RELEASE;
    r.size = SIZE_W'($urandom);
    r.roff = SIZE_W'(off);
    r.rnull = nul;
    return r;
  endfunction

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: one beat per item; valid stays up until accepted. A beat counts
  // as taken once the monitor has seen as many input beats as were offered.
  int send_gap = 0;
  always @(negedge clk) begin
    bit took;
    if (rst_n) begin
      took = in_valid && (in_beats == offered);
      if (took) begin
        send_gap = random_gap();
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
      end
      if ((!in_valid || took) && send_gap == 0 && !hold_sender
          && pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_kind <= pending_reqs[0].kind;
        in_request_size <= pending_reqs[0].size;
        in_release_offset <= pending_reqs[0].roff;
        in_release_null <= pending_reqs[0].rnull;
        offered++;
        void'(pending_reqs.pop_front());
      end else if (took) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls, with a long forced stretch when asked.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_receiver > 0) begin
      out_ready <= 1'b0;
      hold_receiver--;
    end else out_ready <= ($urandom_range(0, 99) < 65);
  end

  // Monitor: predict on input beats, check output beats.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        request_t r;
        r.kind = in_kind;
        r.size = in_request_size;
        r.roff = in_release_offset;
        r.rnull = in_release_null;
        expected_grants.push_back(predict_grant(r));
        in_beats++;
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (expected_grants.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: offset %0d status %0d",
                                     out_data_offset, out_status);
        end else begin
          want = expected_grants.pop_front();
          if (want.offset !== out_data_offset || want.status !== out_status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected offset %0d status %0d, got %0d %0d",
                       want.offset, want.status, out_data_offset, out_status);
          end
        end
      end
      if (idle_cycles >= WDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Fill the queue with a random mix; most releases use offsets on a 16-byte grid above
  // the header, the rest random offsets or null releases.
  task automatic queue_phase(int n);
    for (int j = 0; j < n; j++) begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) begin
        int sz;
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
        pending_reqs.push_back(make_alloc(sz));
      end else if (p < 88) begin
        pending_reqs.push_back(make_release(HDR + 16 * $urandom_range(0, 60), 1'b0));
      end else if (p < 94) begin
        pending_reqs.push_back(make_release($urandom, 1'b0));
      end else begin
        pending_reqs.push_back(make_release($urandom, 1'b1));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    table_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, exact fits, full heap, nulls, unknown, double release.
    pending_reqs.push_back(make_alloc(0));
    pending_reqs.push_back(make_alloc(4095));
    pending_reqs.push_back(make_release(16, 1'b1));
    pending_reqs.push_back(make_release(4095, 1'b0));
    pending_reqs.push_back(make_release(0, 1'b0));
    pending_reqs.push_back(make_release(16, 1'b0));
    pending_reqs.push_back(make_release(16, 1'b0));
    pending_reqs.push_back(make_alloc(HEAP - HDR));
    pending_reqs.push_back(make_alloc(0));
    pending_reqs.push_back(make_release(16, 1'b0));
    pending_reqs.push_back(make_alloc(2048));
    pending_reqs.push_back(make_alloc(2048));
    pending_reqs.push_back(make_alloc(2048 - 2 * HDR));
    pending_reqs.push_back(make_release(16, 1'b0));
    pending_reqs.push_back(make_release(2080, 1'b0));
    // Fill the table with zero-size blocks to reach the full-table case.
    for (int j = 0; j < 66; j++) pending_reqs.push_back(make_alloc(0));
    for (int j = 0; j < 66; j++)
      pending_reqs.push_back(make_release(HDR + 16 * (65 - j), 1'b0));
    pending_reqs.push_back(make_alloc(HEAP - HDR));
    pending_reqs.push_back(make_release(16, 1'b0));
    wait_drained();

    // Long receiver stall while the sender keeps offering.
    hold_receiver = 300;
    queue_phase(40);
    wait_drained();

    // Sender pause until everything has come back.
    hold_sender = 1'b1;
    wait_drained();
    hold_sender = 1'b0;

    queue_phase(900);
    wait_drained();
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_grants.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
